### rtl/tse_pkg.sv
// shared types and constants for the topological sort engine
`default_nettype none

package tse_pkg;

  // widths fixed by the item fields
  localparam int NODE_W = 5;
  localparam int CNT_W  = 6;

  // input item kinds carried in s_tuser
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic edge_wr;
    logic start;
    logic step;
  } tse_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic found;
    logic last_hit;
  } tse_status_t;

endpackage

`default_nettype wire

### rtl/tse_ctrl.sv
// controller state machine for the topological sort engine
`default_nettype none

module tse_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_kind,
  output logic                    in_ready,
  input  wire tse_pkg::tse_status_t status,
  output tse_pkg::tse_cmd_t       cmd
);

  tse_pkg::state_t state;
  tse_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tse_pkg::ST_IDLE: begin
        if (in_valid && in_kind == tse_pkg::CMD_RUN) begin
          state_next = tse_pkg::ST_STEP;
        end
      end
      tse_pkg::ST_STEP: begin
        if (status.out_free && (!status.found || status.last_hit)) begin
          state_next = tse_pkg::ST_IDLE;
        end
      end
      default: state_next = tse_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.edge_wr = 1'b0;
    cmd.start   = 1'b0;
    cmd.step    = 1'b0;
    case (state)
      tse_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.edge_wr = in_valid && (in_kind == tse_pkg::CMD_EDGE);
        cmd.start   = in_valid && (in_kind == tse_pkg::CMD_RUN);
      end
      tse_pkg::ST_STEP: begin
        cmd.step = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/tse_datapath.sv
// dependency matrix, ready search and result register
`default_nettype none

module tse_datapath #(
  parameter int MAX_NODES = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tse_pkg::tse_cmd_t           cmd,
  output tse_pkg::tse_status_t             status,
  input  wire logic [tse_pkg::NODE_W-1:0]  node_index,
  input  wire logic [tse_pkg::NODE_W-1:0]  dependency_index,
  input  wire logic [tse_pkg::CNT_W-1:0]   node_count,
  output logic [tse_pkg::NODE_W-1:0]       ordered_node,
  output logic                             cycle_error,
  output logic                             last,
  output logic                             out_valid,
  input  wire logic                        out_ready
);

  localparam int LIMIT = (MAX_NODES < 32) ? MAX_NODES : 32;
  localparam int RW    = $clog2(LIMIT);

  logic [LIMIT-1:0]              matrix [LIMIT];
  logic [LIMIT-1:0]              removed;
  logic [tse_pkg::CNT_W-1:0]     count;
  logic [tse_pkg::CNT_W-1:0]     n_reg;
  logic [tse_pkg::CNT_W-1:0]     n_clamped;
  logic [tse_pkg::CNT_W-1:0]     count_next;
  logic [LIMIT-1:0]              active;
  logic [LIMIT-1:0]              cand;
  logic [tse_pkg::NODE_W-1:0]    sel_idx;
  logic                          found;
  logic                          last_hit;
  logic                          finish;
  logic                          edge_ok;

  // clamp the node count into the supported range
  always_comb begin
    if (node_count == '0) begin
      n_clamped = tse_pkg::CNT_W'(1);
    end else if (node_count > tse_pkg::CNT_W'(LIMIT)) begin
      n_clamped = tse_pkg::CNT_W'(LIMIT);
    end else begin
      n_clamped = node_count;
    end
  end

  // active nodes and ready candidates, one row each
  always_comb begin
    for (int i = 0; i < LIMIT; i++) begin
      active[i] = (tse_pkg::CNT_W'(i) < n_reg);
    end
    for (int i = 0; i < LIMIT; i++) begin
      cand[i] = active[i] && !removed[i] && ((matrix[i] & active & ~removed) == '0);
    end
  end

  // lowest ready node
  always_comb begin
    sel_idx = '0;
    for (int i = LIMIT - 1; i >= 0; i--) begin
      if (cand[i]) begin
        sel_idx = tse_pkg::NODE_W'(i);
      end
    end
  end

  assign found      = |cand;
  assign count_next = count + tse_pkg::CNT_W'(1);
  assign last_hit   = (count_next == n_reg);
  assign finish     = cmd.step && (!found || last_hit);
  assign edge_ok    = ({1'b0, node_index} < tse_pkg::CNT_W'(LIMIT)) &&
                      ({1'b0, dependency_index} < tse_pkg::CNT_W'(LIMIT));

  assign status.out_free = !out_valid || out_ready;
  assign status.found    = found;
  assign status.last_hit = last_hit;

  // dependency matrix: edge writes, cleared at the end of a run
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      for (int i = 0; i < LIMIT; i++) begin
        matrix[i] <= '0;
      end
    end else if (cmd.edge_wr && edge_ok) begin
      matrix[node_index[RW-1:0]][dependency_index[RW-1:0]] <= 1'b1;
    end
  end

  // run progress
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      removed <= '0;
      count   <= '0;
    end else if (cmd.step) begin
      removed[sel_idx[RW-1:0]] <= 1'b1;
      count                    <= count_next;
    end
  end

  // active node count latched at run start
  always_ff @(posedge clk) begin
    if (rst) begin
      n_reg <= tse_pkg::CNT_W'(1);
    end else if (cmd.start) begin
      n_reg <= n_clamped;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      ordered_node <= found ? sel_idx : '0;
      cycle_error  <= !found;
      last         <= !found || last_hit;
    end
  end

  // run bookkeeping stays consistent
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= n_reg) else $error("emitted count beyond active nodes");

  a_removed_count: assert property (@(posedge clk) disable iff (rst)
    $countones(removed) == int'(count)) else $error("removed mask out of step with count");

  a_error_item: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.step) && !$past(found) |-> cycle_error && last && ordered_node == '0)
    else $error("bad cycle error item");

  a_step_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> status.out_free) else $error("step with result slot busy");

endmodule

`default_nettype wire

### rtl/topological_sort_engine.sv
// Edge loads: one transaction per cycle, no result.
// Run: the run transaction sets the state register to step, then the result register
// takes the first result; then one node per cycle while m_tready is high, set by the
// combinational ready search over the matrix rows; the input is stalled while a run emits.
// Reset (rst, synchronous): matrix cleared, node_count 1, no result pending.
`default_nettype none

module topological_sort_engine #(
  parameter int MAX_NODES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [4:0] node_index, [9:5] dependency_index, rest zero
  input  wire logic        s_tuser,   // [0] cmd
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [4:0] ordered_node, rest zero
  output logic             m_tuser,   // [0] cycle_error
  output logic             m_tlast,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [5:0]  cfg_wr_data
);

  tse_pkg::tse_cmd_t               cmd;
  tse_pkg::tse_status_t            status;
  logic [tse_pkg::CNT_W-1:0]       node_count;
  logic [tse_pkg::NODE_W-1:0]      ordered_node;

  // node count register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= tse_pkg::CNT_W'(1);
    end else if (cfg_wr_en) begin
      node_count <= cfg_wr_data;
    end
  end

  tse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tse_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .node_index       (s_tdata[4:0]),
    .dependency_index (s_tdata[9:5]),
    .node_count       (node_count),
    .ordered_node     (ordered_node),
    .cycle_error      (m_tuser),
    .last             (m_tlast),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready)
  );

  assign m_tdata = {3'b000, ordered_node};

endmodule

`default_nettype wire

### bench/tb_topological_sort_engine.sv
// self-checking testbench for the topological sort engine
`default_nettype none

module tb_topological_sort_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_LIMIT  = 32;
  localparam int SETTLE_CYC  = 40;
  localparam int HOLD_CYC    = 400;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 115;

  // one expected result of a sort run
  typedef struct packed {
    logic [tse_pkg::NODE_W-1:0] node;
    logic                       cycle_err;
    logic                       fin;
  } order_item_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [15:0]                s_tdata = '0;  // [4:0] node_index, [9:5] dependency_index, rest zero
  logic                       s_tuser = tse_pkg::CMD_EDGE;  // [0] cmd
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [7:0]                 m_tdata;   // [4:0] ordered_node, rest zero
  logic                       m_tuser;   // [0] cycle_error
  logic                       m_tlast;
  logic                       cfg_wr_en = 1'b0;
  logic [tse_pkg::CNT_W-1:0]  cfg_wr_data = '0;

  // predictor state
  logic [NODE_LIMIT-1:0]      dep_rows [NODE_LIMIT];
  logic [tse_pkg::CNT_W-1:0]  node_count_shadow;
  order_item_t                pending_order [$];

  int  errors = 0;
  int  cycle_count = 0;
  int  items_accepted = 0;
  int  burst_left = 0;
  bit  steady_send = 1'b0;
  int  hold_requests = 0;

  topological_sort_engine i_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, pending_order.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall pattern, with long hold-offs on request
  always @(posedge clk) begin : rx_stall
    static int hold_taken = 0;
    static int hold_left = 0;
    static int mode_left = 0;
    static rx_mode_t rx_mode = RX_ALWAYS;
    if (hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      hold_left = HOLD_CYC;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (rx_mode)
        RX_ALWAYS: m_tready <= 1'b1;
        RX_COIN:   m_tready <= $urandom_range(0, 1);
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= ~m_tready;
      endcase
    end
  end

  // result check against the oldest expected node
  always @(posedge clk) begin : order_check
    order_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_order.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual node %0d err %0b last %0b",
                 $time, m_tdata, m_tuser, m_tlast);
      end else begin
        want = pending_order.pop_front();
        if (m_tdata !== {{(8-tse_pkg::NODE_W){1'b0}}, want.node}) begin
          errors++;
          $display("%0t: ordered_node mismatch, expected %0d actual %0d",
                   $time, want.node, m_tdata);
        end
        if (m_tuser !== want.cycle_err) begin
          errors++;
          $display("%0t: cycle_error mismatch, expected %0b actual %0b",
                   $time, want.cycle_err, m_tuser);
        end
        if (m_tlast !== want.fin) begin
          errors++;
          $display("%0t: last mismatch, expected %0b actual %0b", $time, want.fin, m_tlast);
        end
      end
    end
  end

  // kahn ordering over the shadow matrix, then clear it
  task automatic sort_graph();
    int n;
    int pick;
    int emitted;
    logic [NODE_LIMIT-1:0] active;
    logic [NODE_LIMIT-1:0] done;
    order_item_t item;
    n = node_count_shadow;
    if (n == 0) n = 1;
    if (n > NODE_LIMIT) n = NODE_LIMIT;
    active = (n == NODE_LIMIT) ? '1 : ((NODE_LIMIT'(1) << n) - 1);
    done = '0;
    emitted = 0;
    while (emitted < n) begin
      pick = -1;
      for (int i = 0; i < n; i++) begin
        if (!done[i] && ((dep_rows[i] & active & ~done) == '0)) begin
          pick = i;
          break;
        end
      end
      if (pick < 0) begin
        item = '{node: '0, cycle_err: 1'b1, fin: 1'b1};
        pending_order = {pending_order, item};
        break;
      end
      done[pick] = 1'b1;
      emitted++;
      item = '{node: tse_pkg::NODE_W'(pick), cycle_err: 1'b0, fin: (emitted == n)};
      pending_order = {pending_order, item};
    end
    for (int i = 0; i < NODE_LIMIT; i++) dep_rows[i] = '0;
  endtask

  // offer one input transaction, with sender bursts and gaps
  task automatic send_item(input logic cmd, input logic [tse_pkg::NODE_W-1:0] node,
                           input logic [tse_pkg::NODE_W-1:0] dep);
    int gap;
    if (burst_left == 0) begin
      gap = steady_send ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'b0, dep, node};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    items_accepted++;
    if (cmd == tse_pkg::CMD_EDGE) begin
      if (node < NODE_LIMIT && dep < NODE_LIMIT) dep_rows[node][dep] = 1'b1;
    end else begin
      sort_graph();
    end
  endtask

  task automatic add_edge(input int node, input int dep);
    send_item(tse_pkg::CMD_EDGE, tse_pkg::NODE_W'(node), tse_pkg::NODE_W'(dep));
  endtask

  // run command with junk in the edge fields
  task automatic run_sort();
    send_item(tse_pkg::CMD_RUN, tse_pkg::NODE_W'($urandom), tse_pkg::NODE_W'($urandom));
  endtask

  // stop sending and let every expected result arrive
  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_order.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [tse_pkg::CNT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    node_count_shadow = value;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // defaults after reset: one active node, self loop and inactive edges
  task automatic test_reset_state();
    run_sort();
    add_edge(0, 0);
    run_sort();
    add_edge(31, 31);
    run_sort();
    drain_results();
  endtask

  // zero is taken as one, above the limit is clamped
  task automatic test_node_count_limits();
    write_node_count(6'd0);
    run_sort();
    drain_results();
    write_node_count(6'd63);
    run_sort();
    drain_results();
  endtask

  // chain with duplicate and inactive edges, then a partial cycle
  task automatic test_small_graphs();
    write_node_count(6'd5);
    add_edge(0, 1);
    add_edge(1, 2);
    add_edge(2, 3);
    add_edge(3, 4);
    add_edge(3, 4);
    add_edge(2, 20);
    add_edge(20, 1);
    run_sort();
    drain_results();
    write_node_count(6'd4);
    add_edge(1, 2);
    add_edge(2, 1);
    run_sort();
    drain_results();
  endtask

  // receiver holds off while full-size runs are queued behind each other
  task automatic test_backpressure();
    write_node_count(6'd32);
    hold_requests++;
    run_sort();
    add_edge(31, 0);
    add_edge(5, 31);
    add_edge(0, 30);
    run_sort();
    run_sort();
    drain_results();
  endtask

  // random graphs, mostly acyclic, over a range of node counts
  task automatic test_random_graphs();
    int perm [NODE_LIMIT];
    int start_items;
    int phase;
    int n;
    int edge_total;
    int kind;
    int a;
    int b;
    int tmp;
    logic [tse_pkg::CNT_W-1:0] count_val;
    start_items = items_accepted;
    phase = 0;
    while (items_accepted - start_items < RANDOM_ITEMS) begin
      case (phase)
        0:       count_val = 6'd1;
        1:       count_val = 6'd32;
        2:       count_val = 6'd63;
        3:       count_val = 6'd0;
        default: count_val = ($urandom_range(0, 3) == 0) ?
                             tse_pkg::CNT_W'($urandom) :
                             tse_pkg::CNT_W'($urandom_range(2, 10));
      endcase
      write_node_count(count_val);
      steady_send = ($urandom_range(0, 3) == 0);
      n = (count_val == 0) ? 1 : ((count_val > NODE_LIMIT) ? NODE_LIMIT : count_val);
      for (int s = 0; s < 3; s++) begin
        // fresh node order for acyclic edges
        for (int i = 0; i < NODE_LIMIT; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--) begin
          a = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[a];
          perm[a] = tmp;
        end
        edge_total = $urandom_range(0, (2 * n > 24) ? 24 : 2 * n);
        for (int e = 0; e < edge_total; e++) begin
          kind = $urandom_range(0, 19);
          if (kind < 14 && n >= 2) begin
            a = $urandom_range(0, n - 2);
            b = $urandom_range(a + 1, n - 1);
            add_edge(perm[b], perm[a]);
          end else if (kind < 17) begin
            add_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
          end else if (kind == 17) begin
            a = $urandom_range(0, n - 1);
            add_edge(a, a);
          end else begin
            add_edge($urandom_range(0, NODE_LIMIT - 1), $urandom_range(0, NODE_LIMIT - 1));
          end
        end
        run_sort();
        // sometimes hold the sender until the run has fully drained
        if ($urandom_range(0, 2) == 0) drain_results();
      end
      drain_results();
      steady_send = 1'b0;
      phase++;
    end
  endtask

  // main sequence
  initial begin
    for (int i = 0; i < NODE_LIMIT; i++) dep_rows[i] = '0;
    node_count_shadow = 6'd1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_node_count_limits();
    test_small_graphs();
    test_backpressure();
    test_random_graphs();
    drain_results();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/tse_pkg.sv
rtl/tse_ctrl.sv
rtl/tse_datapath.sv
rtl/topological_sort_engine.sv
bench/tb_topological_sort_engine.sv
